@@ rtl/core/pixel_mirror_invert_brightness_assert.svh @@
// Assertion macros used by the verification module of the pixel mirror block.
// Needs nothing else; the including file supplies clock, reset and expressions.
`ifndef PIXEL_MIRROR_INVERT_BRIGHTNESS_ASSERT_SVH
`define PIXEL_MIRROR_INVERT_BRIGHTNESS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMIB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pmib assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PMIB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pmib assertion failed");

`endif

@@ rtl/core/pmib_pkg.sv @@
// Shared types and constants of the pixel mirror / invert / brightness block.
// No dependencies.
`default_nettype none

package pmib_pkg;

    // One RGB pixel as stored in the line memory.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    // Settings that the shading unit needs.
    typedef struct packed {
        logic       invert;
        logic [8:0] red_off;
        logic [8:0] green_off;
        logic [8:0] blue_off;
    } t_shade_cfg;

    localparam int PIXEL_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [7:0] CHAN_MAX = 8'd255;

    localparam logic [10:0] ROW_WIDTH_RESET = 11'd640;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR_ON    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_ON    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED_OFFSET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_OFFSET  = 3'd5;

    // Input word kinds.
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

endpackage

`default_nettype wire

@@ rtl/core/pixel_mirror_invert_brightness.sv @@
// Top level of the pixel mirror / invert / brightness block.
// Depends on pmib_pkg, pmib_shade and pmib_line_mem.
//
//   Channel   Signals                                      Direction
//   -------   ------------------------------------------   ---------
//   in        i_in_valid, o_in_stall, i_kind, i_*_in       into block
//   out       o_out_valid, i_out_stall, o_*_out, o_row_last out of block
//   cfg       i_cfg_we, i_cfg_idx, i_cfg_data              into block
//
// One word is accepted per clock while o_in_stall is low. Each result passes the
// middle stage (alongside the synchronous line store read) and the output register.
// Reset (synchronous, active low) empties the pipeline, zeroes the column,
// bank and drain counters and loads the register defaults; the line store is
// not cleared. A stall on the output holds the output register, then the
// middle stage, and only then raises o_in_stall.
`default_nettype none

module pixel_mirror_invert_brightness #(
    parameter int MAX_ROW_WIDTH = 1024
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Configuration write port.
    input  wire                                i_cfg_we,
    input  wire [pmib_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [pmib_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input channel.
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire                                i_kind,
    input  wire [7:0]                          i_red_in,
    input  wire [7:0]                          i_green_in,
    input  wire [7:0]                          i_blue_in,
    // Output channel.
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic [7:0]                         o_red_out,
    output logic [7:0]                         o_green_out,
    output logic [7:0]                         o_blue_out,
    output logic                               o_row_last
);
    import pmib_pkg::*;

    // Column index width and count width (a count may equal the maximum width).
    localparam int AW = $clog2(MAX_ROW_WIDTH);
    localparam int CW = $clog2(MAX_ROW_WIDTH + 1);

    // Configuration registers.
    logic [10:0] r_row_width;
    logic        r_mirror_on;
    t_shade_cfg  r_shade_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= ROW_WIDTH_RESET;
            r_mirror_on <= 1'b0;
            r_shade_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ROW_WIDTH:    r_row_width           <= i_cfg_data[10:0];
                REG_MIRROR_ON:    r_mirror_on           <= i_cfg_data[0];
                REG_INVERT_ON:    r_shade_cfg.invert    <= i_cfg_data[0];
                REG_RED_OFFSET:   r_shade_cfg.red_off   <= i_cfg_data[8:0];
                REG_GREEN_OFFSET: r_shade_cfg.green_off <= i_cfg_data[8:0];
                REG_BLUE_OFFSET:  r_shade_cfg.blue_off  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // The effective width clamps a zero width to one and a large width to the
    // store's capacity.
    logic [CW-1:0] eff_width;

    always_comb begin
        if (r_row_width == 11'd0) begin
            eff_width = CW'(1);
        end else if (32'(r_row_width) > 32'(MAX_ROW_WIDTH)) begin
            eff_width = CW'(MAX_ROW_WIDTH);
        end else begin
            eff_width = CW'(r_row_width);
        end
    end

    // Shading happens on the incoming word, before it is stored.
    t_pixel in_pix;
    t_pixel shaded;

    assign in_pix = '{red: i_red_in, green: i_green_in, blue: i_blue_in};

    pmib_shade u_shade (
        .i_cfg (r_shade_cfg),
        .i_pix (in_pix),
        .o_pix (shaded)
    );

    // Pipeline handshake. The middle stage holds the pass-through pixel or
    // marks that its result is the line store read data.
    logic   r_s1_valid;
    logic   r_s1_from_mem;
    logic   r_s1_last;
    t_pixel r_s1_pix;
    logic   r_out_valid;
    logic   r_out_last;
    t_pixel r_out_pix;

    logic out_free;
    logic s1_free;
    logic accept;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_free    = !r_s1_valid || out_free;
    assign accept     = i_in_valid && s1_free;
    assign o_in_stall = !s1_free;

    // Row state.
    logic [AW-1:0] r_fill_col;
    logic          r_fill_bank;
    logic [CW-1:0] r_drain_rem;
    logic [AW-1:0] n_fill_col;
    logic          n_fill_bank;
    logic [CW-1:0] n_drain_rem;

    logic          has_drain;
    logic          is_pixel;
    logic          pass_go;
    logic          store_go;
    logic          drain_go;
    logic          row_end;
    logic [CW-1:0] drain_idx;

    assign has_drain = (r_drain_rem != '0);
    assign is_pixel  = (i_kind == KIND_PIXEL);
    assign pass_go   = accept && is_pixel && !r_mirror_on;
    assign store_go  = accept && is_pixel && r_mirror_on;
    // A drain word always pops a pending pixel; a mirrored pixel pops one too.
    assign drain_go  = accept && has_drain && ((i_kind == KIND_DRAIN) || r_mirror_on);
    assign row_end   = (CW'(r_fill_col) + CW'(1)) >= eff_width;
    assign drain_idx = r_drain_rem - CW'(1);

    always_comb begin
        n_fill_col  = r_fill_col;
        n_fill_bank = r_fill_bank;
        n_drain_rem = r_drain_rem;
        if (drain_go) begin
            n_drain_rem = drain_idx;
        end
        if (pass_go || store_go) begin
            n_fill_col = row_end ? '0 : (r_fill_col + AW'(1));
        end
        // A completed mirrored row swaps banks; any older drain is dropped.
        if (store_go && row_end) begin
            n_fill_bank = !r_fill_bank;
            n_drain_rem = eff_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_col  <= '0;
            r_fill_bank <= 1'b0;
            r_drain_rem <= '0;
        end else begin
            r_fill_col  <= n_fill_col;
            r_fill_bank <= n_fill_bank;
            r_drain_rem <= n_drain_rem;
        end
    end

    // Writes go to the fill bank and reads to the other bank, so the two ports
    // never meet on one entry in the same cycle. The read data register only
    // loads on an accepted word, so it holds while the pipeline is stalled.
    t_pixel mem_rdata;

    pmib_line_mem #(
        .ADDR_W (AW + 1)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (store_go),
        .i_waddr ({r_fill_bank, r_fill_col}),
        .i_wdata (shaded),
        .i_re    (drain_go),
        .i_raddr ({!r_fill_bank, drain_idx[AW-1:0]}),
        .o_rdata (mem_rdata)
    );

    // Middle stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= pass_go || drain_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_from_mem <= drain_go;
            r_s1_pix      <= shaded;
            r_s1_last     <= pass_go ? row_end : (r_drain_rem == CW'(1));
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out_pix  <= r_s1_from_mem ? mem_rdata : r_s1_pix;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_red_out   = r_out_pix.red;
    assign o_green_out = r_out_pix.green;
    assign o_blue_out  = r_out_pix.blue;
    assign o_row_last  = r_out_last;

endmodule

`default_nettype wire

@@ rtl/core/pmib_shade.sv @@
// Per-channel inversion and saturating signed brightness offset.
// Depends on pmib_pkg.
`default_nettype none

module pmib_shade (
    input  wire pmib_pkg::t_shade_cfg i_cfg,
    input  wire pmib_pkg::t_pixel     i_pix,
    output pmib_pkg::t_pixel          o_pix
);
    import pmib_pkg::*;

    function automatic logic [7:0] shade_chan(input logic [7:0] v, input logic inv,
                                              input logic [8:0] off);
        logic [7:0]        base;
        logic signed [9:0] sum;
        begin
            base = inv ? (CHAN_MAX - v) : v;
            sum  = $signed({2'b00, base}) + $signed({off[8], off});
            if (sum < 10'sd0) begin
                shade_chan = 8'd0;
            end else if (sum > $signed({2'b00, CHAN_MAX})) begin
                shade_chan = CHAN_MAX;
            end else begin
                shade_chan = sum[7:0];
            end
        end
    endfunction

    always_comb begin
        o_pix.red   = shade_chan(i_pix.red,   i_cfg.invert, i_cfg.red_off);
        o_pix.green = shade_chan(i_pix.green, i_cfg.invert, i_cfg.green_off);
        o_pix.blue  = shade_chan(i_pix.blue,  i_cfg.invert, i_cfg.blue_off);
    end

endmodule

`default_nettype wire

@@ rtl/core/pmib_line_mem.sv @@
// Two-bank line store: one write port, one read port with registered read data.
// Depends on pmib_pkg.
`default_nettype none

module pmib_line_mem #(
    parameter int ADDR_W = 11
) (
    input  wire                           i_clk,
    input  wire                           i_we,
    input  wire [ADDR_W-1:0]              i_waddr,
    input  wire pmib_pkg::t_pixel         i_wdata,
    input  wire                           i_re,
    input  wire [ADDR_W-1:0]              i_raddr,
    output pmib_pkg::t_pixel              o_rdata
);
    import pmib_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    t_pixel r_mem [0:DEPTH-1];
    t_pixel r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/pmib_checker.sv @@
// Port-level checks of the pixel mirror block, bound to its top level.
// Depends on pmib_pkg and pixel_mirror_invert_brightness_assert.svh.
`default_nettype none

`include "pixel_mirror_invert_brightness_assert.svh"

module pmib_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_in_valid,
    input wire                             o_in_stall,
    input wire                             o_out_valid,
    input wire                             i_out_stall,
    input wire [7:0]                       o_red_out,
    input wire [7:0]                       o_green_out,
    input wire [7:0]                       o_blue_out,
    input wire                             o_row_last
);
    import pmib_pkg::*;

    logic        in_acc;
    logic [24:0] out_word;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_word = {o_red_out, o_green_out, o_blue_out, o_row_last};

    // A stalled result stays offered.
    `PMIB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // A stalled result keeps its payload.
    `PMIB_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(out_word))

    // Input backpressure only appears once the output itself is held.
    `PMIB_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // A result appearing on an empty output comes from a word that was accepted and then passed the middle stage.
    `PMIB_ASSERT_NOW(a_out_origin, i_clk, i_rst_n, $rose(o_out_valid), $past(in_acc, 2))

endmodule

bind pixel_mirror_invert_brightness pmib_checker u_pmib_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out),
    .o_row_last  (o_row_last)
);

`default_nettype wire

@@ test/pixel_mirror_invert_brightness_tb.sv @@
// Self-checking testbench for the pixel mirror / invert / brightness block.
// It drives random and directed pixel and drain words and checks every output word
// against a cycle-free predictor. Depends only on pmib_pkg and the block itself.
`timescale 1ns / 1ps

module pixel_mirror_invert_brightness_tb;

    import pmib_pkg::*;

    localparam int MAX_W         = 1024;
    // Stimulus stops once this many pixel words and draining drain words went in.
    localparam int RANDOM_WORDS  = 1900;
    // Cycles to let a word with no output leave the two-stage pipeline.
    localparam int SETTLE_CYCLES = 8;
    // Length of each long output hold-off.
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 200000;

    // Predicts the output words of the block and checks the ones that arrive.
    class pixel_scoreboard;
        typedef struct packed {
            t_pixel px;
            logic   row_last;
        } t_out_word;

        t_pixel            line_mem [2*MAX_W];
        bit                line_written [2*MAX_W];
        int unsigned       column;
        int unsigned       drain_left;
        bit                bank;
        logic [10:0]       width_reg;
        logic              mirror;
        logic              invert;
        logic signed [8:0] red_off;
        logic signed [8:0] green_off;
        logic signed [8:0] blue_off;
        t_out_word         expected_q[$];
        int                errors;

        function new();
            column     = 0;
            drain_left = 0;
            bank       = 1'b0;
            width_reg  = ROW_WIDTH_RESET;
            mirror     = 1'b0;
            invert     = 1'b0;
            red_off    = '0;
            green_off  = '0;
            blue_off   = '0;
            errors     = 0;
            foreach (line_written[i]) line_written[i] = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ROW_WIDTH:    width_reg = data[10:0];
                REG_MIRROR_ON:    mirror    = data[0];
                REG_INVERT_ON:    invert    = data[0];
                REG_RED_OFFSET:   red_off   = data[8:0];
                REG_GREEN_OFFSET: green_off = data[8:0];
                REG_BLUE_OFFSET:  blue_off  = data[8:0];
                default: ;
            endcase
        endfunction

        // A width of zero acts as one, and anything past the store acts as the store size.
        function int unsigned span_of(logic [10:0] width);
            if (width == 0) return 1;
            if (width > MAX_W) return MAX_W;
            return width;
        endfunction

        function logic [7:0] shade(logic [7:0] value, logic signed [8:0] offset);
            int x;
            x = value;
            if (invert) x = int'(CHAN_MAX) - x;
            x = x + offset;
            if (x < 0) x = 0;
            if (x > int'(CHAN_MAX)) x = CHAN_MAX;
            return x[7:0];
        endfunction

        // Sends out the next pixel of the finished row, last column first.
        function void emit_pending();
            t_out_word w;
            if (drain_left == 0) return;
            w.px       = line_mem[(bank ? 0 : MAX_W) + drain_left - 1];
            w.row_last = (drain_left == 1);
            expected_q.push_back(w);
            drain_left--;
        endfunction

        // True when finishing the current row with mirroring on reads only stored pixels.
        function bit mirror_safe(int unsigned span);
            for (int unsigned c = 0; c < column && c < span; c++) begin
                if (!line_written[(bank ? MAX_W : 0) + c]) return 1'b0;
            end
            return 1'b1;
        endfunction

        // Notes one accepted word; returns 1 when it causes an output word.
        function bit note_word(logic kind, logic [7:0] red, logic [7:0] green,
                               logic [7:0] blue);
            int unsigned span;
            int unsigned col;
            int          queued;
            t_pixel      px;
            t_out_word   w;
            queued = expected_q.size();
            if (kind == KIND_DRAIN) begin
                emit_pending();
                return expected_q.size() != queued;
            end
            span     = span_of(width_reg);
            px.red   = shade(red, red_off);
            px.green = shade(green, green_off);
            px.blue  = shade(blue, blue_off);
            col      = column;
            if (!mirror) begin
                w.px       = px;
                w.row_last = (col + 1 >= span);
                expected_q.push_back(w);
                column = w.row_last ? 0 : col + 1;
                return 1'b1;
            end
            if (col < MAX_W) begin
                line_mem[(bank ? MAX_W : 0) + col]     = px;
                line_written[(bank ? MAX_W : 0) + col] = 1'b1;
            end
            emit_pending();
            if (col + 1 >= span) begin
                column     = 0;
                bank       = !bank;
                drain_left = span;
            end else begin
                column = col + 1;
            end
            return expected_q.size() != queued;
        endfunction

        function void check_result(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                                   logic row_last);
            t_out_word w;
            if (expected_q.size() == 0) begin
                $error("output word arrived with no expected word pending");
                errors++;
                return;
            end
            w = expected_q.pop_front();
            if (red !== w.px.red) begin
                $error("red_out: expected %0d, actual %0d", w.px.red, red);
                errors++;
            end
            if (green !== w.px.green) begin
                $error("green_out: expected %0d, actual %0d", w.px.green, green);
                errors++;
            end
            if (blue !== w.px.blue) begin
                $error("blue_out: expected %0d, actual %0d", w.px.blue, blue);
                errors++;
            end
            if (row_last !== w.row_last) begin
                $error("row_last: expected %0d, actual %0d", w.row_last, row_last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = REG_ROW_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_kind     = KIND_PIXEL;
    logic [7:0]            i_red_in   = '0;
    logic [7:0]            i_green_in = '0;
    logic [7:0]            i_blue_in  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [7:0]            o_red_out;
    logic [7:0]            o_green_out;
    logic [7:0]            o_blue_out;
    logic                  o_row_last;

    pixel_scoreboard sb = new();

    // Sender pacing, stimulus count and the hold-off requests shared with the receiver.
    int burst_left   = 0;
    int stim_count   = 0;
    int holds_asked  = 0;
    int holds_served = 0;
    int hold_left    = 0;
    int stall_mode   = 0;
    int mode_left    = 0;
    int cycle_count  = 0;

    pixel_mirror_invert_brightness #(
        .MAX_ROW_WIDTH(MAX_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_red_in   (i_red_in),
        .i_green_in (i_green_in),
        .i_blue_in  (i_blue_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_red_out  (o_red_out),
        .o_green_out(o_green_out),
        .o_blue_out (o_blue_out),
        .o_row_last (o_row_last)
    );

    always #5 i_clk = ~i_clk;

    // A hung handshake or a lost output word ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("pixel_mirror_invert_brightness_tb: errors");
            $finish;
        end
    end

    // Receiver. Every output word taken at this edge is checked, then the stall for
    // the next edge is chosen. The stall follows a pattern that switches between
    // free flow, light and heavy random stalls and alternate cycles; a hold-off
    // request from the stimulus side freezes the output for a long hold-off so
    // that the pipeline fills and the block stalls its input.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_red_out, o_green_out, o_blue_out, o_row_last);
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (holds_served < holds_asked) begin
            holds_served = holds_served + 1;
            hold_left    = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 96);
            end
            mode_left = mode_left - 1;
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 99) < 25);
                2:       i_out_stall <= ($urandom_range(0, 99) < 60);
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return CHAN_MAX;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [8:0] pick_offset();
        case ($urandom_range(0, 19))
            0:       return 9'h100;
            1:       return 9'h101;
            2:       return 9'd255;
            3:       return 9'd0;
            default: return 9'($urandom_range(0, 510) - 255);
        endcase
    endfunction

    // Offers one word and returns at the edge where it was taken. The sender runs in
    // bursts; between bursts valid drops for a random gap, and a zero gap keeps valid
    // high so that back-to-back words flow.
    task automatic send_word(logic kind, logic [7:0] red, logic [7:0] green,
                             logic [7:0] blue);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(1, 24);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left = burst_left - 1;
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_red_in   <= red;
        i_green_in <= green;
        i_blue_in  <= blue;
        do @(posedge i_clk); while (o_in_stall);
        // Drain words that find nothing pending are ignored by the block and not counted.
        if (sb.note_word(kind, red, green, blue) || kind == KIND_PIXEL) begin
            stim_count = stim_count + 1;
        end
    endtask

    task automatic send_random(logic kind);
        send_word(kind, rand_chan(), rand_chan(), rand_chan());
    endtask

    // Waits until every expected word is out, then lets words that cause no output
    // leave the pipeline before anything is reconfigured.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    // Writes all six registers. Bits above each register's width carry random values
    // since the block must ignore them.
    task automatic write_config(logic [10:0] width, logic mirror, logic invert,
                                logic [8:0] red_off, logic [8:0] green_off,
                                logic [8:0] blue_off);
        logic [CFG_DATA_W-1:0] junk;
        wait_idle();
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_ROW_WIDTH, width);
        write_reg(REG_MIRROR_ON, {junk[CFG_DATA_W-1:1], mirror});
        write_reg(REG_INVERT_ON, {junk[CFG_DATA_W-2:0], invert});
        write_reg(REG_RED_OFFSET, {junk[1:0], red_off});
        write_reg(REG_GREEN_OFFSET, {junk[4:3], green_off});
        write_reg(REG_BLUE_OFFSET, {junk[7:6], blue_off});
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned span;
        int          rows;
        int          pick;
        logic [10:0] width;
        logic        mirror;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: 640 wide, no mirror, no inversion, zero offsets. A drain
        // word with nothing pending gives no output.
        send_random(KIND_DRAIN);
        send_word(KIND_PIXEL, 8'h00, 8'h00, 8'h00);
        send_word(KIND_PIXEL, 8'hFF, 8'h80, 8'h01);

        // A width of zero acts as one; the column is already past it, so the next
        // pixel ends the row. Offsets at both saturation limits.
        write_config(11'd0, 1'b0, 1'b0, 9'd255, 9'h101, 9'h100);
        send_word(KIND_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_word(KIND_PIXEL, 8'h00, 8'h00, 8'h00);

        // Three-wide mirrored rows with inversion: an empty drain, a full row, one
        // drain word and then the next row pushing out the rest of the first.
        write_config(11'd3, 1'b1, 1'b1, 9'd255, 9'h101, 9'd0);
        send_random(KIND_DRAIN);
        send_word(KIND_PIXEL, 8'h00, 8'hFF, 8'h10);
        send_word(KIND_PIXEL, 8'hFF, 8'h00, 8'h20);
        send_word(KIND_PIXEL, 8'h7F, 8'h80, 8'h30);
        send_random(KIND_DRAIN);
        send_random(KIND_PIXEL);
        send_random(KIND_PIXEL);

        // Width lowered to the current column: the next pixel ends the row at once.
        // Then the row is flushed with drain words, the last of which finds nothing.
        write_config(11'd2, 1'b1, 1'b0, 9'h1FF, 9'd1, 9'd128);
        send_random(KIND_PIXEL);
        repeat (3) send_random(KIND_DRAIN);

        // The widest register value acts as the store size.
        write_config(11'd2047, 1'b0, 1'b1, 9'd0, 9'd0, 9'd0);
        send_word(KIND_PIXEL, 8'hFF, 8'h00, 8'hFF);
        send_word(KIND_PIXEL, 8'h00, 8'hFF, 8'h00);
        send_random(KIND_PIXEL);

        // Random phases. Most are whole rows followed by a flush; the rest are loose
        // mixes of pixel and drain words that leave rows part filled across settings.
        while (stim_count < RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                width = (pick == 0) ? 11'd1024 : 11'($urandom_range(1024, 2047));
            end else if (pick < 8) begin
                width = 11'd0;
            end else if (pick < 50) begin
                width = 11'($urandom_range(1, 4));
            end else if (pick < 85) begin
                width = 11'($urandom_range(5, 16));
            end else begin
                width = 11'($urandom_range(17, 48));
            end
            span   = sb.span_of(width);
            // Mirroring is only turned on where the row in progress would not drain
            // store entries that were never filled.
            mirror = ($urandom_range(0, 3) != 0);
            if (mirror && !sb.mirror_safe(span)) mirror = 1'b0;
            write_config(width, mirror, 1'($urandom_range(0, 1)), pick_offset(),
                         pick_offset(), pick_offset());

            if (stim_count >= 500 && holds_asked == 0) begin
                holds_asked = 1;
            end else if (stim_count >= 1300 && holds_asked == 1) begin
                holds_asked = 2;
            end

            if (span > 64) begin
                // Wide rows only ever get a short partial run.
                repeat ($urandom_range(20, 40)) begin
                    send_random(($urandom_range(0, 5) == 0) ? KIND_DRAIN : KIND_PIXEL);
                end
            end else if ($urandom_range(0, 4) != 0) begin
                rows = (span > 16) ? $urandom_range(1, 2) : $urandom_range(1, 6);
                repeat (rows * span) begin
                    if ($urandom_range(0, 9) == 0) send_random(KIND_DRAIN);
                    send_random(KIND_PIXEL);
                end
                repeat (span + $urandom_range(0, 2)) send_random(KIND_DRAIN);
            end else begin
                repeat ($urandom_range(5, 40)) begin
                    send_random($urandom_range(0, 1) ? KIND_DRAIN : KIND_PIXEL);
                end
            end
        end

        wait_idle();
        if (sb.errors == 0) begin
            $display("pixel_mirror_invert_brightness_tb: clean");
        end else begin
            $display("pixel_mirror_invert_brightness_tb: errors");
        end
        $finish;
    end

endmodule
